[sv/maes_pkg.sv]
// Package for the masked AES-128 encryption core: S-box, round helpers, FSM type.
// No dependencies.
`timescale 1ns / 1ps

package maes_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned ROUND_W = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
            8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
            8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
            8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
            8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
            8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
            8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
            8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
            8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
            8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
            8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
            8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
            8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
            8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
            8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
            8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
            8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
            8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
            8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
            8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
            8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
            8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
            8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
            8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
            8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
            8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
            8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
            8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
            8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
            8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
            8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
            8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
            8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
            8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
            8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
            8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
            8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
            8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
            8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
            8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
            8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
            8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
            8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
            8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
            8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
            8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
            8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
            8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
            8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
            8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
            8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
            8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
            8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // xtime in GF(2^8)
    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // byte i of a 128-bit state, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    // MixColumns on all four columns
    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a, b, x, d;
        for (int c = 0; c < 4; c++)
        begin
            a = s[127-32*c -: 8];
            b = s[119-32*c -: 8];
            x = s[111-32*c -: 8];
            d = s[103-32*c -: 8];
            o[127-32*c -: 8] = dbl(a) ^ dbl(b) ^ b ^ x ^ d;
            o[119-32*c -: 8] = a ^ dbl(b) ^ dbl(x) ^ x ^ d;
            o[111-32*c -: 8] = a ^ b ^ dbl(x) ^ dbl(d) ^ d;
            o[103-32*c -: 8] = dbl(a) ^ a ^ b ^ x ^ dbl(d);
        end
        return o;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd0: v = 8'h01; 4'd1: v = 8'h02; 4'd2: v = 8'h04; 4'd3: v = 8'h08;
            4'd4: v = 8'h10; 4'd5: v = 8'h20; 4'd6: v = 8'h40; 4'd7: v = 8'h80;
            4'd8: v = 8'h1B; 4'd9: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[sv/maes_if.sv]
// Valid/ready stream interfaces for the masked AES core.
// Does not depend on maes_pkg; the widths are written out in the interfaces.
`timescale 1ns / 1ps

interface maes_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [7:0]  main_mask;
    logic [7:0]  column_mask_0;
    logic [7:0]  column_mask_1;
    logic [7:0]  column_mask_2;
    logic [7:0]  column_mask_3;
    modport source (output valid, block_high, block_low, main_mask, column_mask_0,
                    column_mask_1, column_mask_2, column_mask_3, input ready);
    modport sink (input valid, block_high, block_low, main_mask, column_mask_0,
                  column_mask_1, column_mask_2, column_mask_3, output ready);
endinterface

interface maes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    modport source (output valid, cipher_high, cipher_low, input ready);
    modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

[sv/maes_ctrl.sv]
// Round sequencer for the masked AES core.
// Depends on maes_pkg.
`timescale 1ns / 1ps

module maes_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output maes_pkg::ctrl_t                 ctrl,
    output logic [maes_pkg::ROUND_W-1:0]    round
);

    maes_pkg::state_t state_reg, state_next;
    logic [maes_pkg::ROUND_W-1:0] round_reg, round_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= maes_pkg::ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        case (state_reg)
            maes_pkg::ST_IDLE:
            begin
                round_next = '0;
                if (in_valid)
                    state_next = maes_pkg::ST_ROUND;
            end
            maes_pkg::ST_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == maes_pkg::ROUND_W'(maes_pkg::NUM_ROUNDS - 1))
                    state_next = maes_pkg::ST_DONE;
            end
            maes_pkg::ST_DONE:
            begin
                if (out_ready)
                    state_next = maes_pkg::ST_IDLE;
            end
            default: state_next = maes_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        ctrl      = '0;
        case (state_reg)
            maes_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            maes_pkg::ST_ROUND: ctrl.step = 1'b1;
            maes_pkg::ST_DONE:  out_valid = 1'b1;
            default: ;
        endcase
    end

    assign round = round_reg;

endmodule

[sv/maes_round.sv]
// Masked round datapath: state, key and mask registers, one round per step.
// Depends on maes_pkg.
`timescale 1ns / 1ps

module maes_round
(
    input  logic                          clk,
    input  maes_pkg::ctrl_t               ctrl,
    input  logic [maes_pkg::ROUND_W-1:0]  round,
    input  logic [127:0]                  block,
    input  logic [127:0]                  key,
    input  logic [7:0]                    mask,
    input  logic [31:0]                   cmask,
    output logic [127:0]                  result
);

    logic [127:0] state_reg, state_next;
    logic [127:0] key_reg, key_next;
    logic [7:0]   m_reg;
    logic [127:0] rowm_reg, colm_reg;
    logic [127:0] rowm_in, colm_in, mm_in, mm;
    logic [127:0] ss, rk, mixed;
    logic [7:0]   b;
    logic         last;

    // replicate masks over the state
    always_comb
    begin
        rowm_in = {4{cmask}};
        colm_in = maes_pkg::mix(rowm_in);
        mm_in   = {16{mask}};
        mm      = {16{m_reg}};
    end

    assign last = (round == maes_pkg::ROUND_W'(maes_pkg::NUM_ROUNDS - 1));

    // masked SubBytes and ShiftRows
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                b = maes_pkg::get_byte(state_reg, r + 4*((c + r) & 3)) ^ m_reg;
                ss[127-8*(r+4*c) -: 8] = maes_pkg::sbox(b) ^ m_reg;
            end
        end
    end

    // on-the-fly key schedule
    always_comb
    begin
        rk = key_reg;
        rk[127 -: 8] = key_reg[127 -: 8] ^ maes_pkg::rcon(round)
                       ^ maes_pkg::sbox(key_reg[23:16]);
        rk[119 -: 8] = key_reg[119 -: 8] ^ maes_pkg::sbox(key_reg[15:8]);
        rk[111 -: 8] = key_reg[111 -: 8] ^ maes_pkg::sbox(key_reg[7:0]);
        rk[103 -: 8] = key_reg[103 -: 8] ^ maes_pkg::sbox(key_reg[31:24]);
        for (int i = 4; i < 16; i++)
            rk[127-8*i -: 8] = key_reg[127-8*i -: 8] ^ rk[127-8*(i-4) -: 8];
    end

    // remask to row masks and mix
    assign mixed = maes_pkg::mix(ss ^ mm ^ rowm_reg);

    // load, round step and final unmasking
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        if (ctrl.load)
        begin
            state_next = block ^ key ^ mm_in;
            key_next   = key;
        end
        else if (ctrl.step)
        begin
            key_next = rk;
            if (last)
                state_next = ss ^ rk ^ mm;
            else
                state_next = mixed ^ rk ^ colm_reg ^ mm;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
        if (ctrl.load)
        begin
            m_reg    <= mask;
            rowm_reg <= rowm_in;
            colm_reg <= colm_in;
        end
    end

    assign result = state_reg;

endmodule

[sv/masked_aes128_encrypt.sv]
// Top level of the masked AES-128 encryption core.
// Depends on maes_pkg, maes_if, maes_ctrl, maes_round.
//
//  channel  | dir | beat payload
//  ---------+-----+-----------------------------------------------
//  din      | in  | block_high, block_low, main_mask, column_mask_0..3
//  dout     | out | cipher_high, cipher_low
//  cfg      | in  | cfg_we, cfg_index, cfg_data (key_high, key_low)
//
// After acceptance a beat runs its ten rounds, one masked round per cycle
// through the shared round unit; the result is held until taken.
// A new beat is accepted only after the last one has passed acceptance, the
// rounds and the result beat; a result that waits holds off the next beat.
// In is not ready from acceptance until the result beat is taken.
// rst_n clears the sequencer and key registers; no clearing pass.
`timescale 1ns / 1ps

module masked_aes128_encrypt
(
    input  logic                              clk,
    input  logic                              rst_n,
    maes_in_if.sink                           din,
    maes_out_if.source                        dout,
    input  logic                              cfg_we,
    input  logic [maes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [maes_pkg::HALF_W-1:0]       cfg_data
);

    logic [63:0] key_high_reg, key_low_reg;
    maes_pkg::ctrl_t ctrl;
    logic [maes_pkg::ROUND_W-1:0] round;
    logic [127:0] result;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == maes_pkg::REG_KEY_HIGH)
                key_high_reg <= cfg_data;
            if (cfg_index == maes_pkg::REG_KEY_LOW)
                key_low_reg <= cfg_data;
        end
    end

    maes_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .ctrl      (ctrl),
        .round     (round)
    );

    maes_round u_round
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .round  (round),
        .block  ({din.block_high, din.block_low}),
        .key    ({key_high_reg, key_low_reg}),
        .mask   (din.main_mask),
        .cmask  ({din.column_mask_0, din.column_mask_1,
                  din.column_mask_2, din.column_mask_3}),
        .result (result)
    );

    assign dout.cipher_high = result[127:64];
    assign dout.cipher_low  = result[63:0];

endmodule

[sv/maes_checker.sv]
// Port-level checker for the masked AES core, bound to the top level.
// Depends on masked_aes128_encrypt ports.
`timescale 1ns / 1ps

module maes_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // never ready for input while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("in_ready with out_valid");

    // accepted beat yields no output in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    // not ready right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready while busy");

    // result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind masked_aes128_encrypt maes_checker u_maes_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready)
);
